>>> rtl/first_fit_block_allocator_macros.svh
// Assertion macros used by the allocator sequencer
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_MACROS_SVH

// Same-cycle implication, checked outside reset
`define FFBA_HOLD(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define FFBA_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/ffba_pkg.sv
// Package: sizes, codes and shared types of the first-fit block allocator
`timescale 1ns / 1ps
package ffba_pkg;

    localparam int MAX_BLOCKS = 32;
    localparam int HEAP_BYTES = 65536;

    localparam int IDX_W     = $clog2(MAX_BLOCKS);
    localparam int CNT_W     = $clog2(MAX_BLOCKS + 1);
    localparam int ADDR_W    = 16;
    localparam int LIMIT_W   = 17;
    localparam int HDR_W     = 8;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 2;

    // growth may never pass the smaller of the heap size and the 64 KiB window
    localparam int LIM_CAP = (HEAP_BYTES < 65536) ? HEAP_BYTES : 65536;

    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ZERO    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OOM     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOBLOCK = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_HEAP_LIMIT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEADER_BYTES = 2'd1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_DONE
    } ffba_state_t;

    // search word handed from cell to cell
    typedef struct packed {
        logic              valid;
        logic              op;
        logic [ADDR_W-1:0] req_size;
        logic [ADDR_W-1:0] address;
        logic              hit;
        logic              drop;
        logic [ADDR_W-1:0] hit_start;
        logic [ADDR_W-1:0] hit_size;
    } ffba_tok_t;

    // controller state seen by every cell, plus the append write
    typedef struct packed {
        logic [CNT_W-1:0]   count;
        logic [LIMIT_W-1:0] top;
        logic               wr_en;
        logic [IDX_W-1:0]   wr_idx;
        logic [ADDR_W-1:0]  wr_start;
        logic [ADDR_W-1:0]  wr_size;
    } ffba_bcast_t;

endpackage

>>> rtl/ffba_if.sv
// Channel interfaces: request, response and configuration write
`timescale 1ns / 1ps
interface ffba_cmd_if;
    import ffba_pkg::*;
    logic              valid;
    logic              ready;
    logic              op;
    logic [ADDR_W-1:0] req_size;
    logic [ADDR_W-1:0] address;
    modport source (output valid, op, req_size, address, input ready);
    modport sink (input valid, op, req_size, address, output ready);
endinterface

interface ffba_rsp_if;
    import ffba_pkg::*;
    logic                valid;
    logic                ready;
    logic [ADDR_W-1:0]   result_address;
    logic [STATUS_W-1:0] status;
    logic                reused;
    logic                top_released;
    modport source (output valid, result_address, status, reused, top_released, input ready);
    modport sink (input valid, result_address, status, reused, top_released, output ready);
endinterface

interface ffba_cfg_if;
    import ffba_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [LIMIT_W-1:0]   data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/first_fit_block_allocator.sv
// Top level: sequencer plus a chain of table cells that the search word walks through
//
//  channel | dir | handshake     | payload
//  cfg     | in  | valid / ready | index, data (heap_limit, header_bytes)
//  cmd     | in  | valid / ready | op, req_size, address
//  rsp     | out | valid / ready | result_address, status, reused, top_released
//
// From accept to response valid, the search word walks through the MAX_BLOCKS registered
// cells; the sequencer then captures it from the last cell and loads the response register.
// A new request is taken only after the previous response is loaded.
// cfg is always ready. The response sits in an output register; a stalled rsp holds
// the sequencer in its final update step, so no request is taken until the word leaves.
// Reset empties the table and clears the heap top; no clearing pass is needed.
`timescale 1ns / 1ps
module first_fit_block_allocator (
    input  logic       clk,
    input  logic       rst_n,
    ffba_cfg_if.sink   cfg,
    ffba_cmd_if.sink   cmd,
    ffba_rsp_if.source rsp
);
    import ffba_pkg::*;

    ffba_tok_t   tok [MAX_BLOCKS+1];
    ffba_bcast_t bcast;

    ffba_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .cmd         (cmd),
        .rsp         (rsp),
        .chain_end   (tok[MAX_BLOCKS]),
        .chain_start (tok[0]),
        .bcast       (bcast)
    );

    for (genvar g = 0; g < MAX_BLOCKS; g++)
    begin : g_cell
        ffba_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .idx     (IDX_W'(g)),
            .bcast   (bcast),
            .tok_in  (tok[g]),
            .tok_out (tok[g+1])
        );
    end

endmodule

>>> rtl/ffba_cell.sv
// One table entry: holds start, size and free flag, and checks the passing search word
`timescale 1ns / 1ps
module ffba_cell (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [ffba_pkg::IDX_W-1:0]     idx,
    input  ffba_pkg::ffba_bcast_t          bcast,
    input  ffba_pkg::ffba_tok_t            tok_in,
    output ffba_pkg::ffba_tok_t            tok_out
);
    import ffba_pkg::*;

    logic [ADDR_W-1:0]  start_reg;
    logic [ADDR_W-1:0]  size_reg;
    logic               free_reg;
    ffba_tok_t          tok_reg;
    ffba_tok_t          tok_next;

    logic               live;
    logic               alloc_hit;
    logic               rel_hit;
    logic               is_last;
    logic               ends_at_top;
    logic               drop_now;
    logic [LIMIT_W-1:0] end_sum;

    always_comb
    begin
        live        = tok_in.valid && (CNT_W'(idx) < bcast.count);
        alloc_hit   = live && !tok_in.hit && (tok_in.op == OP_ALLOC) && free_reg
                      && (size_reg >= tok_in.req_size);
        rel_hit     = live && !tok_in.hit && (tok_in.op == OP_RELEASE)
                      && (start_reg == tok_in.address);
        is_last     = (CNT_W'(idx) + CNT_W'(1)) == bcast.count;
        end_sum     = LIMIT_W'(tok_in.address) + LIMIT_W'(size_reg);
        ends_at_top = end_sum == bcast.top;
        drop_now    = rel_hit && is_last && ends_at_top;

        tok_next = tok_in;
        if (alloc_hit || rel_hit)
        begin
            tok_next.hit       = 1'b1;
            tok_next.drop      = drop_now;
            tok_next.hit_start = start_reg;
            tok_next.hit_size  = size_reg;
        end
    end

    // entry contents stay undefined until the append write lands here
    always_ff @(posedge clk)
    begin
        if (bcast.wr_en && (bcast.wr_idx == idx))
        begin
            start_reg <= bcast.wr_start;
            size_reg  <= bcast.wr_size;
            free_reg  <= 1'b0;
        end
        else if (alloc_hit)
        begin
            free_reg <= 1'b0;
        end
        else if (rel_hit && !drop_now)
        begin
            free_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

>>> rtl/ffba_ctrl.sv
// Sequencer: takes requests, launches the search word, finishes the table update
`timescale 1ns / 1ps
`include "first_fit_block_allocator_macros.svh"
module ffba_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    ffba_cfg_if.sink              cfg,
    ffba_cmd_if.sink              cmd,
    ffba_rsp_if.source            rsp,
    input  ffba_pkg::ffba_tok_t   chain_end,
    output ffba_pkg::ffba_tok_t   chain_start,
    output ffba_pkg::ffba_bcast_t bcast
);
    import ffba_pkg::*;

    localparam logic [CNT_W-1:0] WALK_LAST = CNT_W'(MAX_BLOCKS);
    localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(MAX_BLOCKS);
    localparam logic [LIMIT_W-1:0] CAP     = LIMIT_W'(LIM_CAP);

    ffba_state_t         state_reg, state_next;
    logic [CNT_W-1:0]    walk_cnt_reg;
    logic                op_reg;
    logic [ADDR_W-1:0]   req_reg;
    logic [ADDR_W-1:0]   addr_reg;
    ffba_tok_t           fin_reg;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [LIMIT_W-1:0]  top_reg, top_next;
    logic [LIMIT_W-1:0]  limit_reg;
    logic [HDR_W-1:0]    header_reg;

    logic                rsp_valid_reg;
    logic [ADDR_W-1:0]   rsp_addr_reg;
    logic [STATUS_W-1:0] rsp_status_reg;
    logic                rsp_reused_reg;
    logic                rsp_toprel_reg;

    logic                cmd_ready;
    logic                capture;
    logic                finish;
    logic                out_free;
    logic                zero_req;

    logic [LIMIT_W-1:0]  payload;
    logic [LIMIT_W:0]    end_sum;
    logic [LIMIT_W-1:0]  eff_limit;
    logic [LIMIT_W-1:0]  drop_amt;
    logic                oom;
    logic                app_en;
    logic [ADDR_W-1:0]   rs_addr;
    logic [STATUS_W-1:0] rs_status;
    logic                rs_reused;
    logic                rs_toprel;

    assign out_free = !rsp_valid_reg || rsp.ready;
    assign zero_req = (op_reg == OP_ALLOC) && (req_reg == '0);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                if (walk_cnt_reg == WALK_LAST)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // fsm outputs
    always_comb
    begin
        cmd_ready = 1'b0;
        capture   = 1'b0;
        finish    = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                cmd_ready = 1'b1;
            end
            S_WALK:
            begin
                capture = walk_cnt_reg == WALK_LAST;
            end
            S_DONE:
            begin
                finish = out_free;
            end
            default:
            begin
                cmd_ready = 1'b0;
            end
        endcase
    end

    assign cmd.ready = cmd_ready;
    assign cfg.ready = 1'b1;

    // launch the search word into the first cell on the first walk cycle, unless the request is a zero-size alloc
    always_comb
    begin
        chain_start           = '0;
        chain_start.valid     = (state_reg == S_WALK) && (walk_cnt_reg == '0) && !zero_req;
        chain_start.op        = op_reg;
        chain_start.req_size  = req_reg;
        chain_start.address   = addr_reg;
    end

    // result and table update once the word has left the last cell
    always_comb
    begin
        payload   = top_reg + LIMIT_W'(header_reg);
        end_sum   = {1'b0, payload} + (LIMIT_W + 1)'(req_reg);
        eff_limit = (limit_reg > CAP) ? CAP : limit_reg;
        oom       = (count_reg == CNT_FULL) || (end_sum > {1'b0, eff_limit});
        drop_amt  = LIMIT_W'(fin_reg.hit_size) + LIMIT_W'(header_reg);

        rs_addr    = '0;
        rs_status  = ST_OK;
        rs_reused  = 1'b0;
        rs_toprel  = 1'b0;
        app_en     = 1'b0;
        count_next = count_reg;
        top_next   = top_reg;

        if (op_reg == OP_ALLOC)
        begin
            if (zero_req)
            begin
                rs_status = ST_ZERO;
            end
            else if (fin_reg.hit)
            begin
                rs_addr   = fin_reg.hit_start;
                rs_reused = 1'b1;
            end
            else if (oom)
            begin
                rs_status = ST_OOM;
            end
            else
            begin
                app_en     = 1'b1;
                rs_addr    = payload[ADDR_W-1:0];
                count_next = count_reg + CNT_W'(1);
                top_next   = end_sum[LIMIT_W-1:0];
            end
        end
        else
        begin
            if (!fin_reg.hit)
            begin
                rs_status = ST_NOBLOCK;
            end
            else if (fin_reg.drop)
            begin
                rs_toprel  = 1'b1;
                count_next = count_reg - CNT_W'(1);
                top_next   = (top_reg > drop_amt) ? (top_reg - drop_amt) : '0;
            end
        end
    end

    always_comb
    begin
        bcast          = '0;
        bcast.count    = count_reg;
        bcast.top      = top_reg;
        bcast.wr_en    = finish && app_en;
        bcast.wr_idx   = count_reg[IDX_W-1:0];
        bcast.wr_start = payload[ADDR_W-1:0];
        bcast.wr_size  = req_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            walk_cnt_reg  <= '0;
            fin_reg       <= '0;
            count_reg     <= '0;
            top_reg       <= '0;
            limit_reg     <= LIMIT_W'(65536);
            header_reg    <= HDR_W'(24);
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cmd.valid && cmd_ready)
            begin
                walk_cnt_reg <= '0;
            end
            else if (state_reg == S_WALK)
            begin
                walk_cnt_reg <= walk_cnt_reg + CNT_W'(1);
            end

            if (capture)
            begin
                fin_reg <= chain_end;
            end

            if (finish)
            begin
                count_reg <= count_next;
                top_reg   <= top_next;
            end

            if (cfg.valid)
            begin
                case (cfg.index)
                    REG_HEAP_LIMIT:   limit_reg  <= cfg.data;
                    REG_HEADER_BYTES: header_reg <= cfg.data[HDR_W-1:0];
                    default:          ;
                endcase
            end

            // hold the word until taken
            if (finish)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd_ready)
        begin
            op_reg   <= cmd.op;
            req_reg  <= cmd.req_size;
            addr_reg <= cmd.address;
        end
        if (finish)
        begin
            rsp_addr_reg   <= rs_addr;
            rsp_status_reg <= rs_status;
            rsp_reused_reg <= rs_reused;
            rsp_toprel_reg <= rs_toprel;
        end
    end

    assign rsp.valid          = rsp_valid_reg;
    assign rsp.result_address = rsp_addr_reg;
    assign rsp.status         = rsp_status_reg;
    assign rsp.reused         = rsp_reused_reg;
    assign rsp.top_released   = rsp_toprel_reg;

    `FFBA_NEXT(a_accept_walk, cmd.valid && cmd_ready, state_reg == S_WALK && walk_cnt_reg == '0, "accepted word did not start a walk")
    `FFBA_NEXT(a_walk_done, state_reg == S_WALK && walk_cnt_reg == WALK_LAST, state_reg == S_DONE, "walk overran the chain")
    `FFBA_HOLD(a_count_range, 1'b1, count_reg <= CNT_FULL, "block count beyond table size")
    `FFBA_HOLD(a_top_range, 1'b1, top_reg <= CAP, "heap top beyond heap window")
    `FFBA_HOLD(a_drop_hit, state_reg == S_DONE && fin_reg.drop, fin_reg.hit, "top drop without a matching block")

endmodule
